// ----- hw/rtl/byte_memory_sized_load_store_defines.svh -----
// Assertion macros used by the checker of the byte memory block.
`ifndef BYTE_MEMORY_SIZED_LOAD_STORE_DEFINES_SVH
`define BYTE_MEMORY_SIZED_LOAD_STORE_DEFINES_SVH

// Implication that is switched off while reset is high.
`define BMSLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked in reset as well.
`define BMSLS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bmsls_pkg.sv -----
package bmsls_pkg;

  // Memory size in address bits; the memory holds 2**ADDR_BITS bytes.
  localparam int ADDR_BITS = 16;

  // The input address field has a fixed width.
  localparam int IN_ADDR_BITS = 16;

  // Four byte lanes, one per byte of a word.
  localparam int LANE_BITS = 2;
  localparam int NUM_LANES = 1 << LANE_BITS;
  localparam int ROW_BITS  = ADDR_BITS - LANE_BITS;
  localparam int ROWS      = 1 << ROW_BITS;

  // Access operations.
  typedef enum logic [2:0] {
    OP_LB  = 3'd0,
    OP_LH  = 3'd1,
    OP_LW  = 3'd2,
    OP_LBU = 3'd3,
    OP_LHU = 3'd4,
    OP_SB  = 3'd5,
    OP_SH  = 3'd6,
    OP_SW  = 3'd7
  } op_t;

endpackage

// ----- hw/rtl/byte_memory_sized_load_store.sv -----
// Loads: a load passes the lane read register, then the result register, which raises done.
// Throughput: one access per cycle if not busy; lane memories read and may write each cycle.
// Stores give no result; the receiver cannot stall, so results are never held.
// Reset: rst starts a clearing pass over all ROWS (16384) rows, one row of all four lanes
// a cycle, and busy stays high until it ends.
module byte_memory_sized_load_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [bmsls_pkg::IN_ADDR_BITS-1:0] byte_address,
  input  logic [31:0] store_data,
  output logic        done,
  output logic [31:0] load_data
);

  localparam int AB = bmsls_pkg::ADDR_BITS;
  localparam int LB = bmsls_pkg::LANE_BITS;
  localparam int RB = bmsls_pkg::ROW_BITS;
  localparam int NL = bmsls_pkg::NUM_LANES;

  logic          clearing;
  logic [RB-1:0] clear_row;

  logic          accept;
  logic          is_store;
  logic [2:0]    store_bytes;
  logic [AB-1:0] addr;
  logic [LB-1:0] lane_off;
  logic [RB-1:0] base_row;

  logic [7:0]    rd_data [NL];

  logic          s1_valid;
  logic [2:0]    s1_op;
  logic [LB-1:0] s1_off;
  logic [31:0]   word;
  logic [31:0]   ext_word;

  // Clearing pass after reset: one row of every lane per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      clear_row <= clear_row + 1'b1;
      if (clear_row == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing;

  // Beat acceptance and address split into lane offset and row.
  assign accept   = start && !busy;
  assign addr     = AB'(byte_address);
  assign lane_off = addr[LB-1:0];
  assign base_row = addr[AB-1:LB];
  assign is_store = accept && (op inside {bmsls_pkg::OP_SB, bmsls_pkg::OP_SH, bmsls_pkg::OP_SW});

  // Number of bytes a store writes.
  always_comb begin
    case (op)
      bmsls_pkg::OP_SB: store_bytes = 3'd1;
      bmsls_pkg::OP_SH: store_bytes = 3'd2;
      bmsls_pkg::OP_SW: store_bytes = 3'd4;
      default:          store_bytes = 3'd0;
    endcase
  end

  // One byte memory per lane. Lane b holds byte k = b - offset of the access,
  // and moves to the next row when the access wraps past lane three.
  for (genvar b = 0; b < NL; b++) begin : g_lane
    logic [7:0]    mem [bmsls_pkg::ROWS];
    logic [LB-1:0] k;
    logic [RB-1:0] row;
    logic          we;
    logic [7:0]    wdata;
    logic          mem_we;
    logic [RB-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    assign k         = LB'(b) - lane_off;
    assign row       = base_row + RB'(LB'(b) < lane_off);
    assign we        = is_store && ({1'b0, k} < store_bytes);
    assign wdata     = store_data[8 * k +: 8];
    assign mem_we    = clearing || we;
    assign mem_addr  = clearing ? clear_row : row;
    assign mem_wdata = clearing ? 8'h00 : wdata;

    always_ff @(posedge clk) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wdata;
      end
      rd_data[b] <= mem[row];
    end
  end

  // Read stage: remember what the load needs to assemble its word.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (op inside {bmsls_pkg::OP_LB, bmsls_pkg::OP_LH, bmsls_pkg::OP_LW,
                                        bmsls_pkg::OP_LBU, bmsls_pkg::OP_LHU});
    end
    s1_op  <= op;
    s1_off <= lane_off;
  end

  // Rotate the lanes so that byte zero of the access lands lowest.
  always_comb begin
    for (int j = 0; j < NL; j++) begin
      word[8 * j +: 8] = rd_data[LB'(s1_off + LB'(j))];
    end
  end

  // Sign or zero extension per operation.
  always_comb begin
    case (s1_op)
      bmsls_pkg::OP_LB:  ext_word = {{24{word[7]}}, word[7:0]};
      bmsls_pkg::OP_LH:  ext_word = {{16{word[15]}}, word[15:0]};
      bmsls_pkg::OP_LBU: ext_word = {24'h000000, word[7:0]};
      bmsls_pkg::OP_LHU: ext_word = {16'h0000, word[15:0]};
      default:           ext_word = word;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    load_data <= ext_word;
  end

endmodule

// ----- hw/rtl/bmsls_checker.sv -----
`include "byte_memory_sized_load_store_defines.svh"

module bmsls_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  op,
  input logic [15:0] byte_address,
  input logic [31:0] store_data,
  input logic        done,
  input logic [31:0] load_data
);

  logic load_beat;
  logic store_beat;
  logic lbu_beat;

  // Beats that the block takes in, split by kind.
  assign load_beat  = !rst && start && !busy
                      && (op inside {bmsls_pkg::OP_LB, bmsls_pkg::OP_LH, bmsls_pkg::OP_LW,
                                     bmsls_pkg::OP_LBU, bmsls_pkg::OP_LHU});
  assign store_beat = !rst && start && !busy
                      && (op inside {bmsls_pkg::OP_SB, bmsls_pkg::OP_SH, bmsls_pkg::OP_SW});
  assign lbu_beat   = !rst && start && !busy && (op == bmsls_pkg::OP_LBU);

  // Every load raises done once it has passed the lane read register and the result register.
  `BMSLS_ASSERT_IMP(a_load_done, clk, rst, load_beat, ##2 done, "load gave no result")

  // A store never gives a result.
  `BMSLS_ASSERT_IMP(a_store_quiet, clk, rst, store_beat, ##2 !done, "store gave a result")

  // An unsigned byte load is zero above its byte.
  `BMSLS_ASSERT_IMP(a_lbu_zero, clk, rst, lbu_beat, ##2 (load_data[31:8] == 24'h000000),
                    "unsigned byte load not zero extended")

  // Reset always starts the clearing pass, which holds off new beats.
  `BMSLS_ASSERT_NEXT(a_reset_busy, clk, rst, busy, "not busy after reset")

endmodule

bind byte_memory_sized_load_store bmsls_checker u_bmsls_checker (.*);
